// File: src/mfpe_pkg.sv
// shared types and constants of the monochrome framebuffer pixel engine
`default_nettype none
package mfpe_pkg;

  localparam int ColumnsDef = 128;
  localparam int PagesDef   = 8;

  // item queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  localparam logic [3:0] PageCmdHi = 4'hB;
  localparam logic [3:0] ColLoCmd  = 4'h0;
  localparam logic [3:0] ColHiCmd  = 4'h1;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_INVERT = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT
  } back_st_e;

  typedef struct packed {
    logic [6:0] x;
    logic [2:0] page;
    logic [2:0] bit_sel;
    op_e        op;
    logic       in_store;
  } item_t;

endpackage
`default_nettype wire

// File: src/mfpe_front.sv
// front end: accepts words, classifies them and queues them for the back end
`default_nettype none
module mfpe_front #(
  parameter int COLUMNS = mfpe_pkg::ColumnsDef,
  parameter int PAGES   = mfpe_pkg::PagesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [6:0]       x_i,
  input  wire logic [5:0]       y_i,
  input  wire logic [1:0]       opcode_i,
  input  wire logic             clearing_i,
  output logic                  q_valid_o,
  output mfpe_pkg::item_t       q_item_o,
  input  wire logic             q_pop_i
);

  mfpe_pkg::item_t                  entry_q [mfpe_pkg::QDepth];
  logic [mfpe_pkg::QAw-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mfpe_pkg::QCw-1:0]         cnt_q, cnt_d;
  mfpe_pkg::item_t                  item_in;
  logic                             push_acc, pop_acc;

  // page and bit are the high and low parts of the row
  always_comb begin
    item_in.x        = x_i;
    item_in.page     = y_i[5:3];
    item_in.bit_sel  = y_i[2:0];
    item_in.op       = mfpe_pkg::op_e'(opcode_i);
    item_in.in_store = ({1'b0, x_i} < 8'(COLUMNS)) && ({1'b0, y_i[5:3]} < 4'(PAGES));
  end

  assign full_o    = clearing_i || (cnt_q == mfpe_pkg::QCw'(mfpe_pkg::QDepth));
  assign push_acc  = push_i && !full_o;
  assign pop_acc   = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_acc) begin
      wr_ptr_d = (wr_ptr_q == mfpe_pkg::QAw'(mfpe_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_acc) begin
      rd_ptr_d = (rd_ptr_q == mfpe_pkg::QAw'(mfpe_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_acc, pop_acc})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule
`default_nettype wire

// File: src/mfpe_back.sv
// back end: frame store, read-modify-write and the byte sequencer
`default_nettype none
module mfpe_back #(
  parameter int COLUMNS = mfpe_pkg::ColumnsDef,
  parameter int PAGES   = mfpe_pkg::PagesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  output logic                  clearing_o,
  input  wire logic             q_valid_i,
  input  wire mfpe_pkg::item_t  q_item_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic [7:0]            out_byte_o,
  output logic                  is_data_o,
  output logic                  pixel_value_o,
  output logic                  last_o
);

  localparam int Depth = PAGES * COLUMNS;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]          mem [Depth];
  logic [7:0]          rdata_q;

  mfpe_pkg::back_st_e  state_q, state_d;
  mfpe_pkg::item_t     cur_q;
  logic [1:0]          cnt_q, cnt_d;
  logic [Aw-1:0]       clr_cnt_q, clr_cnt_d;
  logic                ovalid_q, ovalid_d;
  logic [7:0]          obyte_q;
  logic                odata_q, opix_q, olast_q;

  logic                slot_free, beat_fire, is_rd, last_beat, take, clr_done;
  logic [7:0]          old_byte, new_byte, mask;
  logic                wr_en;
  logic [Aw-1:0]       wr_addr, rd_addr, cur_addr;
  logic [7:0]          beat_byte;
  logic                beat_data, beat_pix;

  assign slot_free = !ovalid_q || pop_i;
  assign is_rd     = (cur_q.op == mfpe_pkg::OP_READ);
  assign last_beat = is_rd || (cnt_q == 2'd3);
  assign beat_fire = (state_q == mfpe_pkg::ST_EMIT) && slot_free;
  assign clr_done  = (clr_cnt_q == Aw'(Depth - 1));
  assign take      = q_valid_i && ((state_q == mfpe_pkg::ST_IDLE) || (beat_fire && last_beat));

  assign rd_addr  = Aw'(32'(q_item_i.page) * 32'(COLUMNS) + 32'(q_item_i.x));
  assign cur_addr = Aw'(32'(cur_q.page) * 32'(COLUMNS) + 32'(cur_q.x));

  // a byte outside the store reads as zero
  always_comb begin
    mask     = 8'd1 << cur_q.bit_sel;
    old_byte = cur_q.in_store ? rdata_q : 8'd0;
    case (cur_q.op)
      mfpe_pkg::OP_SET:    new_byte = old_byte | mask;
      mfpe_pkg::OP_CLEAR:  new_byte = old_byte & ~mask;
      default:             new_byte = old_byte ^ mask;
    endcase
  end

  always_comb begin
    beat_byte = 8'd0;
    beat_data = 1'b0;
    beat_pix  = 1'b0;
    if (is_rd) begin
      beat_pix = |(old_byte & mask);
    end else begin
      case (cnt_q)
        2'd0: beat_byte = {mfpe_pkg::PageCmdHi, 1'b0, cur_q.page};
        2'd1: beat_byte = {mfpe_pkg::ColLoCmd, cur_q.x[3:0]};
        2'd2: beat_byte = {mfpe_pkg::ColHiCmd, 1'b0, cur_q.x[6:4]};
        default: begin
          beat_byte = new_byte;
          beat_data = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mfpe_pkg::ST_CLEAR: if (clr_done) state_d = mfpe_pkg::ST_IDLE;
      mfpe_pkg::ST_IDLE:  if (take) state_d = mfpe_pkg::ST_EMIT;
      mfpe_pkg::ST_EMIT: begin
        if (beat_fire && last_beat && !take) state_d = mfpe_pkg::ST_IDLE;
      end
      default: state_d = mfpe_pkg::ST_CLEAR;
    endcase
  end

  // outputs and counters; store write happens on the first beat so a read on the last beat sees it
  always_comb begin
    clearing_o = (state_q == mfpe_pkg::ST_CLEAR);
    q_pop_o    = take;
    clr_cnt_d  = clr_cnt_q;
    cnt_d      = cnt_q;
    wr_en      = 1'b0;
    wr_addr    = cur_addr;
    ovalid_d   = ovalid_q && !pop_i;
    if (clearing_o) begin
      wr_en     = 1'b1;
      wr_addr   = clr_cnt_q;
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
    if (beat_fire) begin
      ovalid_d = 1'b1;
      if (!last_beat) cnt_d = cnt_q + 1'b1;
      if ((cnt_q == 2'd0) && !is_rd && cur_q.in_store) wr_en = 1'b1;
    end
    if (take) cnt_d = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mfpe_pkg::ST_CLEAR;
      cnt_q     <= '0;
      clr_cnt_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_cnt_q <= clr_cnt_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= q_item_i;
    if (beat_fire) begin
      obyte_q <= beat_byte;
      odata_q <= beat_data;
      opix_q  <= beat_pix;
      olast_q <= last_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= clearing_o ? 8'd0 : new_byte;
  end

  always_ff @(posedge clk_i) begin
    if (take) rdata_q <= mem[rd_addr];
  end

  assign empty_o       = !ovalid_q;
  assign out_byte_o    = obyte_q;
  assign is_data_o     = odata_q;
  assign pixel_value_o = opix_q;
  assign last_o        = olast_q;

endmodule
`default_nettype wire

// File: src/mono_framebuffer_pixel_engine.sv
// top level of the monochrome framebuffer pixel engine
// Keeps a shadow of a page-addressed monochrome display (PAGES pages of COLUMNS
// column bytes) and turns set, clear and invert requests into the four-word
// sequence page command, column-low command, column-high command, data byte;
// a read request returns one word with the pixel bit. Both sides look like a
// queue: push/full in, empty/pop out. After reset the frame store is swept to
// zero one byte a cycle, PAGES*COLUMNS bytes (1024 by default), and full stays
// high until the sweep is done. Afterwards words leave through the single output
// register, one word per cycle while the receiver pops; an item that finds
// the back end idle passes through the queue entry, the registered store read
// and the output register before its first word shows. A two-entry queue sits
// between the front end and the back end, so new requests are taken while words
// drain.
`default_nettype none
module mono_framebuffer_pixel_engine #(
  parameter int COLUMNS = mfpe_pkg::ColumnsDef,
  parameter int PAGES   = mfpe_pkg::PagesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [6:0] x_i,
  input  wire logic [5:0] y_i,
  input  wire logic [1:0] opcode_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            is_data_o,
  output logic            pixel_value_o,
  output logic            last_o
);

  logic            clearing, q_valid, q_pop;
  mfpe_pkg::item_t q_item;

  mfpe_front #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .x_i        (x_i),
    .y_i        (y_i),
    .opcode_i   (opcode_i),
    .clearing_i (clearing),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  mfpe_back #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clearing_o    (clearing),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_byte_o    (out_byte_o),
    .is_data_o     (is_data_o),
    .pixel_value_o (pixel_value_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// File: src/mfpe_checker.sv
// port checker for the pixel engine and its bind
`default_nettype none
module mfpe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic       is_data_o,
  input wire logic       pixel_value_o,
  input wire logic       last_o
);

  // a data word always closes the item
  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_data_o) |-> last_o) else $error("data word not marked last");

  // a pixel bit only comes on a read word, which carries no byte
  a_pix_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pixel_value_o) |-> (last_o && !is_data_o && out_byte_o == 8'd0))
    else $error("pixel bit on a non-read word");

  // a word that is not last is a page or column command
  a_cmd_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> (!is_data_o && (out_byte_o[7:4] == mfpe_pkg::PageCmdHi
      || out_byte_o[7:4] == mfpe_pkg::ColLoCmd || out_byte_o[7:4] == mfpe_pkg::ColHiCmd)))
    else $error("bad command word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_o)))
    else $error("word changed while stalled");

endmodule

bind mono_framebuffer_pixel_engine mfpe_checker u_mfpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_byte_o    (out_byte_o),
  .is_data_o     (is_data_o),
  .pixel_value_o (pixel_value_o),
  .last_o        (last_o)
);
`default_nettype wire

// File: tb/mono_framebuffer_pixel_engine_test.sv
// testbench for the monochrome framebuffer pixel engine: pixel commands in, display words out
`timescale 1ns / 1ps
module mono_framebuffer_pixel_engine_test;

  localparam int COLUMNS = mfpe_pkg::ColumnsDef;
  localparam int PAGES   = mfpe_pkg::PagesDef;

  // one word on the display link, as seen on the result ports
  typedef struct packed {
    logic [7:0] octet;
    logic       is_data;
    logic       pixel;
    logic       last;
  } link_word_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       push     = 1'b0;
  logic       pop      = 1'b0;
  logic [6:0] x_i      = '0;
  logic [5:0] y_i      = '0;
  logic [1:0] opcode_i = '0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic       is_data_o;
  logic       pixel_value_o;
  logic       last_o;

  logic [7:0] shadow_frame [PAGES*COLUMNS];
  link_word_t expected_words [$];
  link_word_t want;

  int mismatches    = 0;
  int words_checked = 0;
  int reads_sent    = 0;
  int writes_sent   = 0;
  int full_stalls   = 0;

  // sender pacing
  bit sender_gaps = 1'b0;
  int burst_left  = 0;

  // receiver stall pattern and long hold-off
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  pattern_pos   = '0;
  int          pop_hold_req  = 0;
  int          pop_hold_left = 0;

  mono_framebuffer_pixel_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .x_i           (x_i),
    .y_i           (y_i),
    .opcode_i      (opcode_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .is_data_o     (is_data_o),
    .pixel_value_o (pixel_value_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // update the shadow frame and queue the words this command should produce
  function automatic void predict_pixel(logic [6:0] x, logic [5:0] y, mfpe_pkg::op_e op);
    logic [2:0] page;
    logic [7:0] mask;
    logic [7:0] cur;
    logic       on_screen;
    int         idx;
    page      = y[5:3];
    mask      = 8'h01 << y[2:0];
    on_screen = (int'(x) < COLUMNS) && (int'(page) < PAGES);
    idx       = int'(page) * COLUMNS + int'(x);
    cur       = on_screen ? shadow_frame[idx] : 8'h00;
    if (op == mfpe_pkg::OP_READ) begin
      expected_words.push_back({8'h00, 1'b0, |(cur & mask), 1'b1});
    end else begin
      case (op)
        mfpe_pkg::OP_SET:   cur = cur | mask;
        mfpe_pkg::OP_CLEAR: cur = cur & ~mask;
        default:            cur = cur ^ mask;
      endcase
      if (on_screen) shadow_frame[idx] = cur;
      // page, column low, column high, then the data word
      expected_words.push_back({mfpe_pkg::PageCmdHi, 1'b0, page, 1'b0, 1'b0, 1'b0});
      expected_words.push_back({mfpe_pkg::ColLoCmd, x[3:0], 1'b0, 1'b0, 1'b0});
      expected_words.push_back({mfpe_pkg::ColHiCmd, 1'b0, x[6:4], 1'b0, 1'b0, 1'b0});
      expected_words.push_back({cur, 1'b1, 1'b0, 1'b1});
    end
  endfunction

  task automatic send_pixel(input logic [6:0] x, input logic [5:0] y,
                            input mfpe_pkg::op_e op);
    int gap;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    push     <= 1'b1;
    x_i      <= x;
    y_i      <= y;
    opcode_i <= op;
    do @(posedge clk_i); while (full);
    predict_pixel(x, y, op);
    if (op == mfpe_pkg::OP_READ) reads_sent++;
    else writes_sent++;
  endtask

  // half of the commands land in a small hot region so reads see earlier writes
  task automatic send_random_pixels(input int count, input int read_pct);
    logic [6:0]    x;
    logic [5:0]    y;
    mfpe_pkg::op_e op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1)) begin
        x = 7'(60 + $urandom_range(0, 3));
        y = 6'($urandom_range(0, 15));
      end else begin
        x = 7'($urandom);
        y = 6'($urandom);
      end
      if ($urandom_range(1, 100) <= read_pct) op = mfpe_pkg::OP_READ;
      else op = mfpe_pkg::op_e'($urandom_range(0, 2));
      send_pixel(x, y, op);
    end
  endtask

  task automatic test_directed_corners();
    sender_gaps   = 1'b0;
    stall_pattern = 16'hFFFF;
    // fresh store reads as zero
    send_pixel(7'd0,   6'd0,  mfpe_pkg::OP_READ);
    send_pixel(7'd127, 6'd63, mfpe_pkg::OP_READ);
    send_pixel(7'd0,   6'd0,  mfpe_pkg::OP_SET);
    send_pixel(7'd0,   6'd0,  mfpe_pkg::OP_READ);
    send_pixel(7'd127, 6'd63, mfpe_pkg::OP_SET);
    send_pixel(7'd127, 6'd63, mfpe_pkg::OP_READ);
    send_pixel(7'd127, 6'd63, mfpe_pkg::OP_INVERT);
    send_pixel(7'd127, 6'd63, mfpe_pkg::OP_READ);
    send_pixel(7'd64,  6'd31, mfpe_pkg::OP_INVERT);
    send_pixel(7'd64,  6'd31, mfpe_pkg::OP_READ);
    // two bits of one byte, then two bits of another
    send_pixel(7'd15,  6'd8,  mfpe_pkg::OP_SET);
    send_pixel(7'd15,  6'd15, mfpe_pkg::OP_SET);
    send_pixel(7'd15,  6'd8,  mfpe_pkg::OP_CLEAR);
    send_pixel(7'd16,  6'd7,  mfpe_pkg::OP_SET);
    send_pixel(7'd16,  6'd0,  mfpe_pkg::OP_INVERT);
    send_pixel(7'd16,  6'd7,  mfpe_pkg::OP_CLEAR);
    // clear of a pixel that is already clear
    send_pixel(7'd127, 6'd0,  mfpe_pkg::OP_CLEAR);
    send_pixel(7'd0,   6'd63, mfpe_pkg::OP_SET);
    send_pixel(7'd0,   6'd0,  mfpe_pkg::OP_CLEAR);
    send_pixel(7'd0,   6'd0,  mfpe_pkg::OP_READ);
    send_pixel(7'd15,  6'd15, mfpe_pkg::OP_READ);
  endtask

  task automatic test_random_traffic();
    sender_gaps   = 1'b1;
    stall_pattern = 16'($urandom) | 16'h0101;
    send_random_pixels(100, 25);
    stall_pattern = 16'($urandom) | 16'h1000;
    send_random_pixels(100, 25);
  endtask

  task automatic test_full_backpressure();
    sender_gaps   = 1'b0;
    stall_pattern = 16'hFFFF;
    pop_hold_req  = 300;
    send_random_pixels(30, 20);
  endtask

  task automatic test_streaming();
    sender_gaps   = 1'b0;
    stall_pattern = 16'hFFFF;
    send_random_pixels(70, 25);
  endtask

  task automatic test_readback();
    sender_gaps   = 1'b1;
    stall_pattern = 16'($urandom) | 16'h8421;
    send_random_pixels(40, 90);
  endtask

  // receiver: long hold-off when asked, otherwise the stall pattern
  always @(posedge clk_i) begin
    if (pop_hold_req != 0) begin
      pop_hold_left = pop_hold_req;
      pop_hold_req  = 0;
    end
    if (pop_hold_left != 0) begin
      pop <= 1'b0;
      pop_hold_left--;
    end else begin
      pop         <= stall_pattern[pattern_pos];
      pattern_pos <= pattern_pos + 4'd1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && full && (reads_sent + writes_sent) > 0) full_stalls++;
    if (rst_ni && pop && !empty) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("word %02h with nothing expected", out_byte_o));
      end else begin
        want = expected_words.pop_front();
        if (out_byte_o !== want.octet)
          flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.octet));
        if (is_data_o !== want.is_data)
          flag_mismatch($sformatf("is_data %b, want %b", is_data_o, want.is_data));
        if (pixel_value_o !== want.pixel)
          flag_mismatch($sformatf("pixel_value %b, want %b", pixel_value_o, want.pixel));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last %b, want %b", last_o, want.last));
      end
    end
  end

  initial begin
    int drain;
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_random_traffic();
    test_full_backpressure();
    test_streaming();
    test_readback();

    push <= 1'b0;
    drain = 0;
    while (expected_words.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (16) @(posedge clk_i);
    if (expected_words.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", expected_words.size()));

    $display("covered %0d writes and %0d reads, %0d words checked",
             writes_sent, reads_sent, words_checked);
    $display("input held off by a full queue for %0d cycles", full_stalls);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d words outstanding", expected_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
src/mfpe_pkg.sv
src/mfpe_front.sv
src/mfpe_back.sv
src/mono_framebuffer_pixel_engine.sv
src/mfpe_checker.sv
tb/mono_framebuffer_pixel_engine_test.sv
